// ===== rtl/cel_pkg.sv =====
// shared types and constants of the compacting entry list
`default_nettype none

package cel_pkg;

  localparam int OP_W   = 2;
  localparam int HASH_W = 32;
  localparam int IDX_W  = 7;
  localparam int REP_W  = 8;
  localparam int GEN_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_APPEND = 3'd1,
    CELL_REMOVE = 3'd2,
    CELL_CLEAR  = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic [HASH_W-1:0] folder;
    logic [HASH_W-1:0] file;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   data;
  } cell_ctl_t;

  typedef struct packed {
    logic              ok;
    logic [REP_W-1:0]  count;
    logic [GEN_W-1:0]  generation;
    logic [REP_W-1:0]  batch_added;
    logic [HASH_W-1:0] read_folder;
    logic [HASH_W-1:0] read_file;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/cel_req_if.sv =====
// request and response channel interfaces
`default_nettype none

interface cel_req_if import cel_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [HASH_W-1:0] dir_hash;
  logic [HASH_W-1:0] name_hash;
  logic [IDX_W-1:0]  index;
  logic              in_batch;
  logic              batch_last;

  modport source (output valid, op, dir_hash, name_hash, index, in_batch, batch_last,
                  input ready);
  modport sink (input valid, op, dir_hash, name_hash, index, in_batch, batch_last,
                output ready);
endinterface

interface cel_rsp_if import cel_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [REP_W-1:0]  count;
  logic [GEN_W-1:0]  generation;
  logic [REP_W-1:0]  batch_added;
  logic [HASH_W-1:0] read_folder;
  logic [HASH_W-1:0] read_file;

  modport source (output valid, ok, count, generation, batch_added, read_folder, read_file,
                  input ready);
  modport sink (input valid, ok, count, generation, batch_added, read_folder, read_file,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/compacting_entry_list.sv =====
// top level: control, counters and the row of list cells
//
//  channel  | dir | handshake         | payload
//  in_req   | in  | valid/ready       | op, dir_hash, name_hash, index, in_batch, batch_last
//  out_rsp  | out | valid/ready       | ok, count, generation, batch_added, read_folder, read_file
//
// add, remove, clear and an invalid read update all cells on the accepting edge and
// go to the hold state, which raises the response once the output register is free,
// so no new request is taken before that; a valid read first rotates the cell row
// once around, capturing slot 0 as the wanted entry passes it, then enters the hold state.
// rst_n clears counters and control; cells need no reset since slots at or
// above the count are never returned.
// one response is held while the next request is taken; a stalled out_rsp
// stops the block after that.
`default_nettype none

module compacting_entry_list import cel_pkg::*; #(
  parameter int MAX_ENTRIES = 128
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cel_req_if.sink   in_req,
  cel_rsp_if.source out_rsp
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int STEP_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int BC_W   = 32;
  localparam logic [CNT_W-1:0]  MAX_C  = CNT_W'(MAX_ENTRIES);
  localparam logic [STEP_W-1:0] LAST_S = STEP_W'(MAX_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROT  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [GEN_W-1:0]  gen_r, gen_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [STEP_W-1:0] rd_idx_r, rd_idx_nxt;
  rsp_t              res_r, res_nxt;
  rsp_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  cell_ctl_t         ctl;
  logic [CNT_W-1:0]  sel;
  entry_t            cell_q [MAX_ENTRIES];

  logic              acc;
  logic              idx_ok;
  logic              app_ok;
  logic              ok;
  logic [BC_W-1:0]   badd;
  op_t               op;

  assign acc    = in_req.valid & in_req.ready;
  assign op     = op_t'(in_req.op);
  assign idx_ok = CMP_W'(in_req.index) < CMP_W'(cnt_r);
  assign app_ok = (cnt_r < MAX_C) && ((in_req.dir_hash != '0) || (in_req.name_hash != '0));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    gen_nxt       = gen_r;
    bc_nxt        = bc_r;
    step_nxt      = step_r;
    rd_idx_nxt    = rd_idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_rsp.ready;
    ctl.op        = CELL_HOLD;
    ctl.data      = '{folder: in_req.dir_hash, file: in_req.name_hash};
    sel           = cnt_r;
    ok            = 1'b0;
    badd          = bc_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = ST_HOLD;
          case (op)
            OP_ADD: begin
              if (app_ok) begin
                ctl.op  = CELL_APPEND;
                cnt_nxt = cnt_r + CNT_W'(1);
                ok      = 1'b1;
                if (in_req.in_batch) bc_nxt = bc_r + BC_W'(1);
                else gen_nxt = gen_r + GEN_W'(1);
              end
              badd = bc_nxt;
              // batch end: one bump for the whole batch if it stored anything
              if (in_req.in_batch && in_req.batch_last) begin
                if (bc_nxt != '0) gen_nxt = gen_r + GEN_W'(1);
                bc_nxt = '0;
              end
            end
            OP_REMOVE: begin
              if (idx_ok) begin
                ctl.op  = CELL_REMOVE;
                sel     = CNT_W'(in_req.index);
                cnt_nxt = cnt_r - CNT_W'(1);
                gen_nxt = gen_r + GEN_W'(1);
                ok      = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (cnt_r != '0) begin
                ctl.op  = CELL_CLEAR;
                cnt_nxt = '0;
                gen_nxt = gen_r + GEN_W'(1);
                ok      = 1'b1;
              end
            end
            OP_READ: begin
              if (idx_ok) begin
                ok         = 1'b1;
                state_nxt  = ST_ROT;
                step_nxt   = '0;
                rd_idx_nxt = STEP_W'(in_req.index);
              end
            end
            default: state_nxt = ST_HOLD;
          endcase
          res_nxt.ok          = ok;
          res_nxt.count       = REP_W'(cnt_nxt);
          res_nxt.generation  = gen_nxt;
          res_nxt.batch_added = REP_W'(badd);
          res_nxt.read_folder = '0;
          res_nxt.read_file   = '0;
        end
      end
      ST_ROT: begin
        // slot 0 holds entry step_r before this shift
        ctl.op = CELL_ROTATE;
        if (step_r == rd_idx_r) begin
          res_nxt.read_folder = cell_q[0].folder;
          res_nxt.read_file   = cell_q[0].file;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_S) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      gen_r       <= '0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gen_r       <= gen_nxt;
      bc_r        <= bc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    rd_idx_r <= rd_idx_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t nbr;
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign nbr = (ctl.op == CELL_ROTATE) ? cell_q[0] : '0;
    end else begin : g_body
      assign nbr = cell_q[i+1];
    end
    cel_cell #(
      .POS   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .sel   (sel),
      .nbr   (nbr),
      .entry (cell_q[i])
    );
  end

  assign in_req.ready        = (state_r == ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.ok          = out_r.ok;
  assign out_rsp.count       = out_r.count;
  assign out_rsp.generation  = out_r.generation;
  assign out_rsp.batch_added = out_r.batch_added;
  assign out_rsp.read_folder = out_r.read_folder;
  assign out_rsp.read_file   = out_r.read_file;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C)
    else $error("entry count above capacity");

  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (gen_r != $past(gen_r))) |-> (gen_r == $past(gen_r) + GEN_W'(1)))
    else $error("generation moved by more than one");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((cnt_r == $past(cnt_r) + CNT_W'(1)) || (cnt_r == $past(cnt_r) - CNT_W'(1)) ||
       (cnt_r == '0)))
    else $error("entry count jumped");

  a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_ADD) && in_req.in_batch && in_req.batch_last) |=> (bc_r == '0))
    else $error("batch count not cleared at batch end");

  a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == ST_HOLD))
    else $error("response raised outside hold state");
`endif

endmodule

`default_nettype wire

// ===== rtl/cel_cell.sv =====
// one slot of the list: holds a hash pair and takes its neighbor's on a shift
`default_nettype none

module cel_cell import cel_pkg::*; #(
  parameter int POS   = 0,
  parameter int CNT_W = 8
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] sel,
  input  wire entry_t           nbr,
  output entry_t                entry
);

  localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

  entry_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      CELL_APPEND: begin
        if (POS_C == sel) entry_nxt = ctl.data;
      end
      // slots at and above the removed one move down by one
      CELL_REMOVE: begin
        if (POS_C >= sel) entry_nxt = nbr;
      end
      CELL_CLEAR:  entry_nxt = '0;
      CELL_ROTATE: entry_nxt = nbr;
      default:     entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== sim/list_checker.sv =====
// scoreboard for the compacting entry list: predicts every response and checks it
`timescale 1ns / 1ps

module list_checker import cel_pkg::*; #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic clk,
  input  logic rst_n,
  cel_req_if   req,
  cel_rsp_if   rsp,
  output int   fail_count,
  output int   awaiting,
  output int   list_len
);

  localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  entry_t           shelf [MAX_ENTRIES] = '{default: '0};
  int               held = 0;
  logic [GEN_W-1:0] gen_now = '0;
  int               batch_run = 0;
  rsp_t             awaited_rsp [$];
  int               failures = 0;
  int               rsp_seen = 0;

  // applies one request to the shadow list and returns the response it should give
  function automatic rsp_t list_response(input op_t op, input entry_t pair,
                                         input logic [IDX_W-1:0] idx,
                                         input logic in_batch, input logic last);
    rsp_t r;
    int   i;
    r = '0;
    case (op)
      OP_ADD: begin
        if (held < MAX_ENTRIES && pair != '0) begin
          shelf[SLOT_W'(held)] = pair;
          held++;
          r.ok = 1'b1;
          if (in_batch) batch_run++;
          else gen_now++;
        end
      end
      OP_REMOVE: begin
        if (int'(idx) < held) begin
          for (i = int'(idx); i + 1 < held; i++) shelf[SLOT_W'(i)] = shelf[SLOT_W'(i + 1)];
          held--;
          shelf[SLOT_W'(held)] = '0;
          gen_now++;
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (held != 0) begin
          for (i = 0; i < held; i++) shelf[SLOT_W'(i)] = '0;
          held = 0;
          gen_now++;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(idx) < held) begin
          r.ok          = 1'b1;
          r.read_folder = shelf[SLOT_W'(idx)].folder;
          r.read_file   = shelf[SLOT_W'(idx)].file;
        end
      end
    endcase
    // batch total is reported before the closing item resets it
    r.batch_added = batch_run[REP_W-1:0];
    if (op == OP_ADD && in_batch && last) begin
      if (batch_run != 0) gen_now++;
      batch_run = 0;
    end
    r.count      = held[REP_W-1:0];
    r.generation = gen_now;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [HASH_W-1:0] got,
                                 input logic [HASH_W-1:0] want);
    failures++;
    if (failures <= 40)
      $display("%0t: response %0d, %s is %0h, expected %0h", $time, rsp_seen, field, got,
               want);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (rsp.valid && rsp.ready) begin
        rsp_seen++;
        if (awaited_rsp.size() == 0) begin
          report_mismatch("unrequested response", 1, 0);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.ok !== want.ok)
            report_mismatch("ok", HASH_W'(rsp.ok), HASH_W'(want.ok));
          if (rsp.count !== want.count)
            report_mismatch("count", HASH_W'(rsp.count), HASH_W'(want.count));
          if (rsp.generation !== want.generation)
            report_mismatch("generation", HASH_W'(rsp.generation), HASH_W'(want.generation));
          if (rsp.batch_added !== want.batch_added)
            report_mismatch("batch_added", HASH_W'(rsp.batch_added),
                            HASH_W'(want.batch_added));
          if (rsp.read_folder !== want.read_folder)
            report_mismatch("read_folder", rsp.read_folder, want.read_folder);
          if (rsp.read_file !== want.read_file)
            report_mismatch("read_file", rsp.read_file, want.read_file);
        end
      end
      if (req.valid && req.ready)
        awaited_rsp.push_back(list_response(op_t'(req.op),
                                            entry_t'({req.dir_hash, req.name_hash}),
                                            req.index, req.in_batch, req.batch_last));
    end
    fail_count <= failures;
    awaiting   <= awaited_rsp.size();
    list_len   <= held;
  end

endmodule

// ===== sim/tb.sv =====
// testbench top: clock, reset, request traffic and response back-pressure for the entry list
`timescale 1ns / 1ps

module tb;
  import cel_pkg::*;

  localparam int MAX_ENTRIES  = 128;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 400;
  localparam int CHURN_PAIRS  = 50;
  localparam int RUN_LIMIT    = 1000000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   awaiting;
  int   list_len;
  int   sent = 0;
  int   tx_idle_pct = 20;
  int   rx_busy_pct = 20;
  int   hold_req = 0;
  int   hold_ack = 0;

  cel_req_if req_if ();
  cel_rsp_if rsp_if ();

  compacting_entry_list #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n), .in_req(req_if), .out_rsp(rsp_if)
  );

  list_checker #(.MAX_ENTRIES(MAX_ENTRIES)) list_check (
    .clk(clk), .rst_n(rst_n), .req(req_if), .rsp(rsp_if),
    .fail_count(fail_count), .awaiting(awaiting), .list_len(list_len)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] wide_hash();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 14) return '1;
    return $urandom;
  endfunction

  function automatic entry_t live_pair();
    entry_t p;
    p.folder = wide_hash();
    p.file   = wide_hash();
    if (p == '0) p.file = 32'h1;
    return p;
  endfunction

  // mostly an index inside the list, sometimes anywhere
  function automatic logic [IDX_W-1:0] pick_index();
    logic [IDX_W-1:0] v;
    if (list_len > 0 && $urandom_range(99) < 80) v = IDX_W'($urandom_range(list_len - 1));
    else v = IDX_W'($urandom);
    return v;
  endfunction

  // valid stays high from one request to the next unless a gap is drawn
  task automatic issue(input op_t op, input logic [HASH_W-1:0] fh, input logic [HASH_W-1:0] ih,
                       input logic [IDX_W-1:0] idx, input logic in_batch, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.dir_hash   <= fh;
    req_if.name_hash  <= ih;
    req_if.index      <= idx;
    req_if.in_batch   <= in_batch;
    req_if.batch_last <= last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic side_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50)
      issue(OP_REMOVE, wide_hash(), wide_hash(), pick_index(), 1'($urandom), 1'($urandom));
    else if (pick < 93)
      issue(OP_READ, wide_hash(), wide_hash(), pick_index(), 1'($urandom), 1'($urandom));
    else
      issue(OP_CLEAR, wide_hash(), wide_hash(), IDX_W'($urandom), 1'($urandom),
            1'($urandom));
  endtask

  // response side: random stalls, plus one long hold-off when asked
  initial begin
    int n;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ack != hold_req) begin
        rsp_if.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_ack = hold_req;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_busy_pct);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    entry_t p;
    int     k;
    int     len;
    int     pick;
    int     base;
    logic   closed;
    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.op         <= OP_ADD;
    req_if.dir_hash   <= '0;
    req_if.name_hash  <= '0;
    req_if.index      <= '0;
    req_if.in_batch   <= 1'b0;
    req_if.batch_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: bad read, bad remove, clear with nothing to clear
    issue(OP_READ, '0, '0, 7'd0, 1'b0, 1'b0);
    issue(OP_REMOVE, '0, '0, 7'd0, 1'b0, 1'b0);
    issue(OP_CLEAR, '0, '0, 7'd0, 1'b0, 1'b0);
    // zero pair dropped; batch_last ignored on a single add
    issue(OP_ADD, '0, '0, 7'd0, 1'b0, 1'b0);
    issue(OP_ADD, '1, '1, 7'd127, 1'b0, 1'b1);
    issue(OP_ADD, '0, 32'h1, 7'd0, 1'b0, 1'b0);
    issue(OP_ADD, 32'h1, '0, 7'd0, 1'b0, 1'b0);
    issue(OP_READ, '0, '0, 7'd0, 1'b0, 1'b0);
    issue(OP_READ, '0, '0, 7'd2, 1'b0, 1'b0);
    issue(OP_READ, '0, '0, 7'd3, 1'b0, 1'b0);
    issue(OP_REMOVE, '0, '0, 7'd1, 1'b0, 1'b0);
    issue(OP_REMOVE, '0, '0, 7'd127, 1'b0, 1'b0);
    // batch left open across read, remove and clear
    issue(OP_ADD, 32'hA5A5_0001, 32'h5A5A_0002, 7'd0, 1'b1, 1'b0);
    issue(OP_READ, '0, '0, 7'd0, 1'b0, 1'b0);
    issue(OP_REMOVE, '0, '0, 7'd0, 1'b0, 1'b0);
    issue(OP_ADD, '0, '0, 7'd0, 1'b1, 1'b0);
    issue(OP_CLEAR, '0, '0, 7'd0, 1'b1, 1'b1);
    issue(OP_ADD, 32'hC0DE_0003, 32'hBEEF_0004, 7'd0, 1'b1, 1'b1);
    // batch that closes without adding anything
    issue(OP_ADD, '0, '0, 7'd0, 1'b1, 1'b1);
    issue(OP_ADD, 32'h1234_5678, 32'h9ABC_DEF0, 7'd0, 1'b0, 1'b0);
    issue(OP_READ, '0, '0, 7'd1, 1'b0, 1'b0);
    issue(OP_CLEAR, '0, '0, 7'd0, 1'b0, 1'b0);

    base = sent;
    while (sent < base + RANDOM_ITEMS) begin
      if (hold_req == 0 && sent >= base + 400) hold_req = 1;
      pick = $urandom_range(99);
      if (pick < 40) begin
        len    = $urandom_range(1, 8);
        closed = ($urandom_range(9) != 0);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(99) < 15) side_request();
          if ($urandom_range(9) == 0) p = '0;
          else p = live_pair();
          issue(OP_ADD, p.folder, p.file, IDX_W'($urandom), 1'b1, closed && k == len - 1);
        end
      end else if (pick < 60) begin
        p = live_pair();
        issue(OP_ADD, p.folder, p.file, IDX_W'($urandom), 1'b0, 1'($urandom));
      end else if (pick < 92) begin
        side_request();
      end else begin
        issue(op_t'(OP_W'($urandom_range(3))), wide_hash(), wide_hash(), IDX_W'($urandom),
              1'($urandom), 1'($urandom));
      end
    end

    // full rate from here: fill the list, then churn it
    tx_idle_pct = 0;
    rx_busy_pct = 0;
    issue(OP_CLEAR, '0, '0, 7'd0, 1'b0, 1'b0);
    for (k = 0; k < MAX_ENTRIES + 2; k++) begin
      p = live_pair();
      issue(OP_ADD, p.folder, p.file, IDX_W'($urandom), 1'b1, k == MAX_ENTRIES + 1);
    end
    p = live_pair();
    issue(OP_ADD, p.folder, p.file, 7'd0, 1'b0, 1'b0);
    issue(OP_READ, '0, '0, 7'd127, 1'b0, 1'b0);
    for (k = 0; k < CHURN_PAIRS; k++) begin
      issue(OP_REMOVE, wide_hash(), wide_hash(), IDX_W'($urandom), 1'b0, 1'b0);
      p = live_pair();
      issue(OP_ADD, p.folder, p.file, IDX_W'($urandom), 1'b0, 1'b0);
    end
    issue(OP_READ, '0, '0, IDX_W'($urandom), 1'b0, 1'b0);

    req_if.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (MAX_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
